// File: rtl/pose_template_distance_core_defines.svh
// assertion macros shared by the rtl
`ifndef POSE_TEMPLATE_DISTANCE_CORE_DEFINES_SVH
`define POSE_TEMPLATE_DISTANCE_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define PTD_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);

`endif

// File: rtl/ptd_pkg.sv
package ptd_pkg;

	localparam int unsigned IDX_W   = 6;
	localparam int unsigned DIST_W  = 18;
	localparam int unsigned SLOT_W  = 3;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned SQ_W    = 34;
	localparam int unsigned SUM_W   = 38;
	localparam int unsigned ROOT_W  = 19;
	localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

	localparam logic signed [COORD_W:0] DEG90  = 17'sd1440;
	localparam logic signed [COORD_W:0] DEG270 = 17'sd4320;
	localparam logic signed [COORD_W:0] DEG360 = 17'sd5760;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clr_sum;
		logic acc;
		logic root_start;
		logic load_out;
	} ptd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic root_busy;
	} ptd_sts_t;

	// wrap-aware angle difference
	function automatic logic [COORD_W:0] angle_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] ea;
		logic signed [COORD_W:0] eb;
		logic signed [COORD_W+1:0] d;
		ea = {a[COORD_W-1], a};
		eb = {b[COORD_W-1], b};
		if (ea >= DEG270 && ea <= DEG360 && eb >= 0 && eb <= DEG90)
			d = {DEG360[COORD_W], DEG360} - {ea[COORD_W], ea} + {eb[COORD_W], eb};
		else if (eb >= DEG270 && eb <= DEG360 && ea >= 0 && ea <= DEG90)
			d = {DEG360[COORD_W], DEG360} - {eb[COORD_W], eb} + {ea[COORD_W], ea};
		else begin
			d = {ea[COORD_W], ea} - {eb[COORD_W], eb};
			if (d < 0)
				d = -d;
		end
		return d[COORD_W:0];
	endfunction

	// plain absolute difference
	function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		logic signed [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		if (d < 0)
			d = -d;
		return d[COORD_W:0];
	endfunction

endpackage

// File: rtl/ptd_isqrt.sv
module ptd_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ptd_pkg::SUM_W-1:0]    value,
	output logic                         busy,
	output logic [ptd_pkg::ROOT_W-1:0]   root
);
	import ptd_pkg::*;

	localparam int unsigned STEPS = SUM_W / 2;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] res_q;
	logic [SUM_W-1:0] bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] trial;

	assign trial = res_q + bit_q;
	assign busy  = (cnt_q != '0);
	assign root  = res_q[ROOT_W-1:0];

	// one result bit per cycle, restoring form
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= SUM_W'(1) << (2 * (STEPS - 1));
		end else if (busy) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// File: rtl/ptd_datapath.sv
`include "pose_template_distance_core_defines.svh"
module ptd_datapath #(
	parameter int unsigned MAX_SAMPLES = 64,
	parameter int unsigned FEATURES    = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptd_pkg::ptd_cmd_t                  cmd,
	output ptd_pkg::ptd_sts_t                  sts,
	input  logic                               st_we,
	input  logic [$clog2(MAX_SAMPLES*FEATURES)-1:0] st_waddr,
	input  logic                               q_we,
	input  logic [ptd_pkg::SLOT_W-1:0]         q_waddr,
	input  logic [31:0]                        wdata,
	input  logic                               rd_en,
	input  logic [$clog2(MAX_SAMPLES*FEATURES)-1:0] st_raddr,
	input  logic [ptd_pkg::SLOT_W-1:0]         q_raddr,
	output logic [ptd_pkg::DIST_W-1:0]         dist_val
);
	import ptd_pkg::*;

	localparam int unsigned DEPTH = MAX_SAMPLES * FEATURES;

	logic [31:0] store_mem [DEPTH];
	logic [31:0] qbuf [FEATURES];
	logic [31:0] st_rd_s1;
	logic [31:0] q_rd_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [COORD_W:0] tx_s2;
	logic [COORD_W:0] ty_s2;
	logic [SQ_W-1:0] sq_s3;
	logic [SUM_W-1:0] sum_q;
	logic [COORD_W:0] tx;
	logic [COORD_W:0] ty;
	logic root_busy;
	logic [ROOT_W-1:0] root;

	// sample memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (st_we)
			store_mem[st_waddr] <= wdata;
		if (rd_en)
			st_rd_s1 <= store_mem[st_raddr];
	end

	// query buffer
	always_ff @(posedge clk) begin
		if (q_we)
			qbuf[q_waddr[$clog2(FEATURES)-1:0]] <= wdata;
		if (rd_en) begin
			q_rd_s1 <= qbuf[q_raddr[$clog2(FEATURES)-1:0]];
			slot_s1 <= q_raddr;
		end
	end

	// per-slot difference terms
	always_comb begin
		if (slot_s1 == SLOT_W'(1)) begin
			tx = angle_diff(st_rd_s1[15:0], q_rd_s1[15:0]);
			ty = angle_diff(st_rd_s1[31:16], q_rd_s1[31:16]);
		end else begin
			tx = abs_diff(st_rd_s1[15:0], q_rd_s1[15:0]);
			ty = abs_diff(st_rd_s1[31:16], q_rd_s1[31:16]);
		end
	end

	always_ff @(posedge clk) begin
		tx_s2 <= tx;
		ty_s2 <= ty;
		sq_s3 <= SQ_W'(tx_s2 * tx_s2) + SQ_W'(ty_s2 * ty_s2);
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (cmd.clr_sum)
			sum_q <= '0;
		else if (cmd.acc)
			sum_q <= sum_q + SUM_W'(sq_s3);
	end

	ptd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.value  (sum_q),
		.busy   (root_busy),
		.root   (root)
	);

	assign sts.root_busy = root_busy;

	// saturated distance
	always_ff @(posedge clk) begin
		if (cmd.load_out)
			dist_val <= root[ROOT_W-1] ? DIST_MAX : root[DIST_W-1:0];
	end

	`PTD_ASSERT_IMP(a_no_acc_in_root, clk, arst_n, cmd.acc, !root_busy,
		"accumulate while root busy")
	`PTD_ASSERT_NXT(a_root_runs, clk, arst_n, cmd.root_start, root_busy,
		"root did not start")
	`PTD_ASSERT_IMP(a_load_idle, clk, arst_n, cmd.load_out, !root_busy,
		"output load during root")
endmodule

// File: rtl/ptd_ctrl.sv
`include "pose_template_distance_core_defines.svh"
module ptd_ctrl #(
	parameter int unsigned MAX_SAMPLES = 64,
	parameter int unsigned FEATURES    = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_fire,
	input  logic                               action,
	input  logic [ptd_pkg::SLOT_W-1:0]         slot,
	output logic                               in_ready,
	output logic                               st_we,
	output logic [$clog2(MAX_SAMPLES*FEATURES)-1:0] st_waddr,
	output logic                               q_we,
	output logic                               rd_en,
	output logic [$clog2(MAX_SAMPLES*FEATURES)-1:0] st_raddr,
	output logic [ptd_pkg::SLOT_W-1:0]         q_raddr,
	output ptd_pkg::ptd_cmd_t                  cmd,
	input  ptd_pkg::ptd_sts_t                  sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ptd_pkg::IDX_W-1:0]          out_idx,
	output logic                               out_last
);
	import ptd_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES * FEATURES);
	localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_ROOT  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] row_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] wbase_q;
	logic [2:0] acc_pipe_q;
	logic [2:0] drain_q;
	logic ok_slot;
	logic last_row;

	assign ok_slot  = ({1'b0, slot} < (SLOT_W + 1)'(FEATURES));
	assign in_ready = (state_q == S_IDLE);
	assign st_we    = in_fire && ok_slot && action == ACT_ADD && count_q < CNT_W'(MAX_SAMPLES);
	assign st_waddr = wbase_q + ADDR_W'(slot);
	assign q_we     = in_fire && ok_slot && action == ACT_QUERY;
	assign rd_en    = (state_q == S_READ);
	assign st_raddr = base_q + ADDR_W'(rslot_q);
	assign q_raddr  = rslot_q;
	assign last_row = (row_q + 1'b1 == count_q);
	assign out_valid = (state_q == S_OUT);
	assign out_idx  = IDX_W'(row_q);
	assign out_last = last_row;

	assign cmd.clr_sum    = (state_q == S_IDLE) || (state_q == S_OUT);
	assign cmd.acc        = acc_pipe_q[2];
	assign cmd.root_start = (state_q == S_DRAIN) && (drain_q == 3'd0) && !acc_pipe_q[2];
	assign cmd.load_out   = (state_q == S_ROOT) && !sts.root_busy;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			row_q      <= '0;
			rslot_q    <= '0;
			base_q     <= '0;
			wbase_q    <= '0;
			acc_pipe_q <= '0;
			drain_q    <= '0;
		end else begin
			acc_pipe_q <= {acc_pipe_q[1:0], rd_en};
			unique case (state_q)
				S_IDLE: begin
					if (st_we && slot == SLOT_W'(FEATURES - 1)) begin
						count_q <= count_q + 1'b1;
						wbase_q <= wbase_q + ADDR_W'(FEATURES);
					end
					if (q_we && slot == SLOT_W'(FEATURES - 1) && count_q != '0) begin
						state_q <= S_READ;
						row_q   <= '0;
						base_q  <= '0;
						rslot_q <= '0;
					end
				end
				S_READ: begin
					if (rslot_q == SLOT_W'(FEATURES - 1)) begin
						state_q <= S_DRAIN;
						drain_q <= 3'd3;
					end else begin
						rslot_q <= rslot_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (drain_q != 3'd0)
						drain_q <= drain_q - 1'b1;
					else
						state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (!sts.root_busy)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_READ;
							row_q   <= row_q + 1'b1;
							base_q  <= base_q + ADDR_W'(FEATURES);
							rslot_q <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTD_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`PTD_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_SAMPLES),
		"sample count overflow")
	`PTD_ASSERT_IMP(a_out_row, clk, arst_n, out_valid, row_q < count_q,
		"output row beyond table")
endmodule

// File: rtl/pose_template_distance_core.sv
// channel | dir | tdata (low bit up)                              | tuser
// s_axis  | in  | feature_slot[2:0], coord_x[18:3], coord_y[34:19] | action
// m_axis  | out | sample_index[5:0], distance[23:6]               | -, tlast = last_of_run
// adds and partial queries do not block input; a completing query blocks input
// while each stored row runs through FEATURES memory reads,
// a short square pipeline and a 19-step bit-serial square root
// each result waits in the output register until m_axis_tready
// arst_n clears the row count and the sequencer; the sample memory needs no clearing
`include "pose_template_distance_core_defines.svh"
module pose_template_distance_core #(
	parameter int unsigned MAX_SAMPLES = 64,
	parameter int unsigned FEATURES    = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // feature_slot, coord_x, coord_y
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // sample_index, distance
	output logic        m_axis_tlast   // last_of_run
);
	import ptd_pkg::*;

	localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES * FEATURES);

	ptd_cmd_t cmd;
	ptd_sts_t sts;
	logic in_fire;
	logic st_we, q_we, rd_en;
	logic [ADDR_W-1:0] st_waddr, st_raddr;
	logic [SLOT_W-1:0] q_raddr;
	logic [IDX_W-1:0] idx;
	logic [DIST_W-1:0] dist_val;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata = {dist_val, idx};

	ptd_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .FEATURES(FEATURES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .action(s_axis_tuser),
		.slot(s_axis_tdata[2:0]), .in_ready(s_axis_tready), .st_we(st_we),
		.st_waddr(st_waddr), .q_we(q_we), .rd_en(rd_en), .st_raddr(st_raddr),
		.q_raddr(q_raddr), .cmd(cmd), .sts(sts), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_idx(idx), .out_last(m_axis_tlast)
	);

	ptd_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .FEATURES(FEATURES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .st_we(st_we),
		.st_waddr(st_waddr), .q_we(q_we), .q_waddr(s_axis_tdata[2:0]),
		.wdata(s_axis_tdata[34:3]), .rd_en(rd_en), .st_raddr(st_raddr),
		.q_raddr(q_raddr), .dist_val(dist_val)
	);

	`PTD_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready,
		"input taken during output")
	`PTD_ASSERT_NXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
	`PTD_ASSERT_IMP(a_tdata_idle, clk, arst_n, cmd.acc, !m_axis_tvalid,
		"accumulate during output")
endmodule

// File: tb/sv/pose_template_distance_core_test.sv
`timescale 1ns / 1ps
module pose_template_distance_core_test;
	import ptd_pkg::*;

	localparam int unsigned ROWS_MAX = 64;
	localparam int unsigned NSLOT = 6;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct packed {
		logic [5:0]  sample_index;
		logic [17:0] distance;
		logic        last_of_run;
	} match_t;

	// running copy of the table and the expected distances
	class match_board;
		logic [31:0] rows[ROWS_MAX*NSLOT];
		logic [31:0] probe[NSLOT];
		int unsigned row_count;
		match_t pending[$];
		int unsigned errors;

		function new();
			row_count = 0;
			errors = 0;
		endfunction

		function longint unsigned angle_gap(int a, int b);
			if (a >= 4320 && a <= 5760 && b >= 0 && b <= 1440)
				return 5760 - a + b;
			if (b >= 4320 && b <= 5760 && a >= 0 && a <= 1440)
				return 5760 - b + a;
			return (a > b) ? a - b : b - a;
		endfunction

		function logic [17:0] row_dist(int unsigned r);
			longint unsigned total, tx, ty, root, bitv, v;
			int ax, ay, bx, by;
			total = 0;
			for (int s = 0; s < NSLOT; s++) begin
				ax = $signed(rows[r*NSLOT+s][15:0]);
				ay = $signed(rows[r*NSLOT+s][31:16]);
				bx = $signed(probe[s][15:0]);
				by = $signed(probe[s][31:16]);
				if (s == 1) begin
					tx = angle_gap(ax, bx);
					ty = angle_gap(ay, by);
				end else begin
					tx = (ax > bx) ? ax - bx : bx - ax;
					ty = (ay > by) ? ay - by : by - ay;
				end
				total += tx * tx + ty * ty;
			end
			// integer square root
			v = total;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v -= root + bitv;
					root = (root >> 1) + bitv;
				end else
					root >>= 1;
				bitv >>= 2;
			end
			return (root > 262143) ? 18'h3FFFF : root[17:0];
		endfunction

		function void note_pair(logic act, logic [2:0] slot, logic [31:0] pair);
			match_t m;
			if (slot >= NSLOT)
				return;
			if (act == ACT_ADD) begin
				if (row_count >= ROWS_MAX)
					return;
				rows[row_count*NSLOT+slot] = pair;
				if (slot == NSLOT-1)
					row_count++;
				return;
			end
			probe[slot] = pair;
			if (slot != NSLOT-1)
				return;
			for (int unsigned r = 0; r < row_count; r++) begin
				m.sample_index = r[5:0];
				m.distance = row_dist(r);
				m.last_of_run = (r + 1 == row_count);
				pending = {pending, m};
			end
		endfunction

		function void check_match(match_t got);
			match_t want;
			if (pending.size() == 0) begin
				$error("unexpected result index %0d", got.sample_index);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sample_index !== want.sample_index) begin
				$error("sample_index expected %0d actual %0d", want.sample_index,
					got.sample_index);
				errors++;
			end
			if (got.distance !== want.distance) begin
				$error("distance expected %0d actual %0d", want.distance, got.distance);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run expected %0d actual %0d", want.last_of_run,
					got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	match_board board;
	int unsigned idle_cycles;
	int unsigned rx_gap;

	pose_template_distance_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// send one item, idling for the given gap first; valid stays up with no gap
	task automatic send_pair(logic act, logic [2:0] slot, logic [15:0] x, logic [15:0] y,
			int unsigned gap);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {5'd0, y, x, slot};
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_pair(act, slot, {y, x});
	endtask

	function automatic logic [15:0] rand_coord(int unsigned mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1440));
			2: return 16'($urandom_range(4320, 5760));
			default: return 16'($urandom_range(0, 4000));
		endcase
	endfunction

	// a full row of adds or a full query, the first slots in random order and the last slot last
	task automatic send_row(logic act, bit noisy, int unsigned mode);
		int order[NSLOT];
		int k, t;
		for (int s = 0; s < NSLOT; s++)
			order[s] = s;
		for (int s = 0; s < NSLOT-1; s++) begin
			k = $urandom_range(s, NSLOT-2);
			t = order[s];
			order[s] = order[k];
			order[k] = t;
		end
		for (int s = 0; s < NSLOT; s++) begin
			if (noisy && $urandom_range(0, 5) == 0)
				send_pair(1'($urandom_range(0, 1)), 3'($urandom_range(6, 7)),
					16'($urandom), 16'($urandom), $urandom_range(0, 15));
			send_pair(act, 3'(order[s]), rand_coord(mode), rand_coord(mode),
				$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
		end
	endtask

	// receiver with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_match({m_axis_tdata[5:0], m_axis_tdata[23:6], m_axis_tlast});
				rx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			end
			if (rx_gap != 0) begin
				m_axis_tready <= 1'b0;
				rx_gap--;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		board = new();
		idle_cycles = 0;
		rx_gap = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table query, extremes, angle wrap cases, bad slots
		send_row(ACT_QUERY, 1'b0, 0);
		send_pair(ACT_ADD, 3'd7, 16'hFFFF, 16'hFFFF, 0);
		send_pair(ACT_QUERY, 3'd6, 16'h0000, 16'h8000, 0);
		for (int s = 0; s < NSLOT; s++)
			send_pair(ACT_ADD, 3'(s), 16'h7FFF, 16'h8000, 0);
		for (int s = 0; s < NSLOT; s++)
			send_pair(ACT_QUERY, 3'(s), 16'h8000, 16'h7FFF, 0);
		send_pair(ACT_ADD, 3'd0, 16'd0, 16'd5760, 1);
		send_pair(ACT_ADD, 3'd1, 16'd4320, 16'd1440, 0);
		send_pair(ACT_ADD, 3'd2, 16'd5760, 16'd0, 0);
		send_pair(ACT_ADD, 3'd3, 16'hFFFF, 16'd1, 0);
		send_pair(ACT_ADD, 3'd4, 16'd1440, 16'd4320, 0);
		send_pair(ACT_ADD, 3'd5, 16'd100, 16'd200, 0);
		send_row(ACT_QUERY, 1'b0, 1);

		// random: mostly adds with some queries until the table is full
		while (board.row_count < ROWS_MAX) begin
			if ($urandom_range(0, 9) < 9)
				send_row(ACT_ADD, $urandom_range(0, 3) == 0, $urandom_range(0, 3));
			else
				send_row(ACT_QUERY, $urandom_range(0, 3) == 0, $urandom_range(0, 3));
		end
		// adds past full, then queries over the whole table
		send_row(ACT_ADD, 1'b1, 0);
		repeat (2)
			send_row(ACT_QUERY, 1'b1, $urandom_range(0, 3));
		s_axis_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
